// ===== rtl/core/hrp_pkg.sv =====
// Shared types, constants and parse-step functions for the HTTP request header parser.
`default_nettype none
package hrp_pkg;

   localparam int OFFSET_BITS_DEFAULT = 16;
   localparam int POS_WIDTH           = 32;
   localparam int RSP_DATA_WIDTH      = 80;

   typedef enum logic [3:0] {
      PH_METHOD   = 4'd0,
      PH_TGT_SKIP = 4'd1,
      PH_TARGET   = 4'd2,
      PH_VER_SKIP = 4'd3,
      PH_VERSION  = 4'd4,
      PH_REQ_LF   = 4'd5,
      PH_KEY      = 4'd6,
      PH_VAL_SKIP = 4'd7,
      PH_VALUE    = 4'd8,
      PH_HDR_LF   = 4'd9,
      PH_DONE     = 4'd10
   } phase_type;

   localparam logic [1:0] KIND_NONE    = 2'd0;
   localparam logic [1:0] KIND_REQUEST = 2'd1;
   localparam logic [1:0] KIND_HEADER  = 2'd2;

   localparam logic [3:0] METHOD_GET     = 4'd0;
   localparam logic [3:0] METHOD_HEAD    = 4'd1;
   localparam logic [3:0] METHOD_POST    = 4'd2;
   localparam logic [3:0] METHOD_PUT     = 4'd3;
   localparam logic [3:0] METHOD_DELETE  = 4'd4;
   localparam logic [3:0] METHOD_CONNECT = 4'd5;
   localparam logic [3:0] METHOD_OPTIONS = 4'd6;
   localparam logic [3:0] METHOD_TRACE   = 4'd7;
   localparam logic [3:0] METHOD_PATH    = 4'd8;
   localparam logic [3:0] METHOD_UNKNOWN = 4'd9;
   localparam int         METHOD_COUNT   = 10;

   localparam logic [1:0] VER_CODE_10  = 2'd0;
   localparam logic [1:0] VER_CODE_11  = 2'd1;
   localparam logic [1:0] VER_CODE_BAD = 2'd2;

   localparam logic [63:0] VER_10_TEXT = "HTTP/1.0";
   localparam logic [63:0] VER_11_TEXT = "HTTP/1.1";

   localparam logic [7:0] CHAR_CR    = 8'h0d;
   localparam logic [7:0] CHAR_COLON = 8'h3a;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_UC_A  = 8'h41;
   localparam logic [7:0] CHAR_UC_Z  = 8'h5a;
   localparam logic [7:0] CASE_DELTA = 8'h20;
   localparam logic [7:0] WILDCARD   = 8'hff;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [15:0] second_length;
      logic [15:0] second_offset;
      logic [15:0] first_length;
      logic [15:0] first_offset;
      logic [1:0]  version_code;
      logic [3:0]  method_code;
      logic [1:0]  record_kind;
      logic [7:0]  out_byte;
   } rsp_type;

   // Working copy of the parse state, positions at full width.
   typedef struct packed {
      phase_type              phase;
      logic [9:0]             alive;
      logic [3:0]             chosen;
      logic [63:0]            head;
      logic [POS_WIDTH-1:0]   tok;
      logic [POS_WIDTH-1:0]   span;
      logic [POS_WIDTH-1:0]   key_start;
      logic [POS_WIDTH-1:0]   key_len;
      logic [3:0]             vcnt;
      logic                   ok10;
      logic                   ok11;
      logic [1:0]             ver_result;
   } ctx_type;

   function automatic logic is_blank(logic [7:0] b);
      return (b == CHAR_SPACE) || (b == CHAR_TAB);
   endfunction

   function automatic logic [63:0] method_text(logic [3:0] code);
      logic [63:0] t;
      case (code)
         METHOD_GET:     t = {"GET", {5{WILDCARD}}};
         METHOD_HEAD:    t = {"HEAD", {4{WILDCARD}}};
         METHOD_POST:    t = {"POST", {4{WILDCARD}}};
         METHOD_PUT:     t = {"PUT", {5{WILDCARD}}};
         METHOD_DELETE:  t = {"DELETE", {2{WILDCARD}}};
         METHOD_CONNECT: t = {"CONNECT", WILDCARD};
         METHOD_OPTIONS: t = {"OPTIONS", WILDCARD};
         METHOD_TRACE:   t = {"TRACE", {3{WILDCARD}}};
         METHOD_PATH:    t = {"PATH", {4{WILDCARD}}};
         default:        t = {8{WILDCARD}};
      endcase
      return t;
   endfunction

   function automatic logic [7:0] method_pat(logic [3:0] code, logic [2:0] p);
      logic [63:0] t;
      t = method_text(code);
      return t[{3'd7 - p, 3'b000} +: 8];
   endfunction

   function automatic logic [3:0] method_len(logic [3:0] code);
      logic [3:0] n;
      case (code)
         METHOD_GET:     n = 4'd3;
         METHOD_HEAD:    n = 4'd4;
         METHOD_POST:    n = 4'd4;
         METHOD_PUT:     n = 4'd3;
         METHOD_DELETE:  n = 4'd6;
         METHOD_CONNECT: n = 4'd7;
         METHOD_OPTIONS: n = 4'd7;
         METHOD_TRACE:   n = 4'd5;
         METHOD_PATH:    n = 4'd4;
         default:        n = 4'd0;
      endcase
      return n;
   endfunction

   function automatic logic [7:0] ver_char(logic [2:0] k, logic minor);
      logic [63:0] t;
      t = minor ? VER_11_TEXT : VER_10_TEXT;
      return t[{3'd7 - k, 3'b000} +: 8];
   endfunction

   // Target / version scanning for one byte of the request line.
   function automatic ctx_type scan_step(ctx_type c, logic [7:0] b,
                                         logic [POS_WIDTH-1:0] pos);
      ctx_type r;
      r = c;
      case (c.phase)
         PH_TGT_SKIP: begin
            if (!is_blank(b)) begin
               r.tok   = pos;
               r.phase = PH_TARGET;
            end
         end
         PH_TARGET: begin
            if (is_blank(b)) begin
               r.span  = pos - c.tok;
               r.phase = PH_VER_SKIP;
            end
         end
         PH_VER_SKIP: begin
            if (!is_blank(b)) begin
               r.vcnt  = 4'd1;
               r.ok10  = (b == ver_char(3'd0, 1'b0));
               r.ok11  = (b == ver_char(3'd0, 1'b1));
               r.phase = PH_VERSION;
            end
         end
         PH_VERSION: begin
            if (c.vcnt < 4'd8) begin
               r.ok10 = c.ok10 && (b == ver_char(c.vcnt[2:0], 1'b0));
               r.ok11 = c.ok11 && (b == ver_char(c.vcnt[2:0], 1'b1));
               r.vcnt = c.vcnt + 4'd1;
            end else begin
               r.vcnt = 4'd9;
            end
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   // Pick the first surviving method, then rescan the held bytes past its name.
   function automatic ctx_type decide(ctx_type c, logic [POS_WIDTH-1:0] e);
      ctx_type    r;
      logic [3:0] stored;
      logic [3:0] len;
      r = c;
      r.chosen = METHOD_UNKNOWN;
      for (int i = METHOD_COUNT - 2; i >= 0; i--) begin
         if (c.alive[i]) r.chosen = 4'(i);
      end
      r.phase = PH_TGT_SKIP;
      stored  = (e > 32'd8) ? 4'd8 : e[3:0];
      len     = method_len(r.chosen);
      for (int p = 0; p < 8; p++) begin
         if ((4'(p) >= len) && (4'(p) < stored))
            r = scan_step(r, c.head[8*p +: 8], POS_WIDTH'(p));
      end
      return r;
   endfunction

   function automatic ctx_type finish_request(ctx_type c, logic [POS_WIDTH-1:0] e);
      ctx_type r;
      r = (c.phase == PH_METHOD) ? decide(c, e) : c;
      r.ver_result = VER_CODE_BAD;
      case (r.phase)
         PH_TGT_SKIP: begin
            r.tok  = e;
            r.span = '0;
         end
         PH_TARGET: r.span = e - r.tok;
         PH_VERSION: begin
            if (r.vcnt == 4'd8 && r.ok10)      r.ver_result = VER_CODE_10;
            else if (r.vcnt == 4'd8 && r.ok11) r.ver_result = VER_CODE_11;
         end
         default: begin
         end
      endcase
      r.phase = PH_REQ_LF;
      return r;
   endfunction

   function automatic ctx_type finish_header(ctx_type c, logic [POS_WIDTH-1:0] e);
      ctx_type r;
      r = c;
      if (c.phase == PH_KEY && e == c.key_start) begin
         // empty line closes the block
         r.phase = PH_DONE;
      end else begin
         case (c.phase)
            PH_KEY: begin
               r.key_len = e - c.key_start;
               r.tok     = e;
               r.span    = '0;
            end
            PH_VAL_SKIP: begin
               r.tok  = e;
               r.span = '0;
            end
            PH_VALUE: r.span = e - c.tok;
            default: begin
            end
         endcase
         r.phase = PH_HDR_LF;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/hrp_input_stage.sv =====
// Input register stage: holds one accepted byte until the parse engine consumes it.
`default_nettype none
module hrp_input_stage (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire logic [7:0]       req_tdata,
   input  wire logic             req_tlast,
   input  wire logic             fire,
   output logic                  item_valid,
   output hrp_pkg::req_type      item
);

   logic             valid_ff;
   logic             valid_in;
   hrp_pkg::req_type item_ff;

   assign req_tready = !valid_ff || fire;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (req_tvalid && req_tready) valid_in = 1'b1;
      else if (fire)                valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff.data <= req_tdata;
         item_ff.last <= req_tlast;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/hrp_parse_engine.sv =====
// Parse state registers and the one-byte next-state and record logic.
`default_nettype none
module hrp_parse_engine #(
   parameter int OFFSET_BITS = hrp_pkg::OFFSET_BITS_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             fire,
   input  wire hrp_pkg::req_type item,
   output hrp_pkg::rsp_type      result
);

   localparam logic [hrp_pkg::POS_WIDTH-1:0] POS_MASK =
      hrp_pkg::POS_WIDTH'((64'd1 << OFFSET_BITS) - 64'd1);

   hrp_pkg::phase_type     phase_ff, phase_in;
   logic [OFFSET_BITS-1:0] pos_ff, pos_in;
   logic [9:0]             alive_ff, alive_in;
   logic [3:0]             chosen_ff, chosen_in;
   logic [63:0]            head_ff, head_in;
   logic [OFFSET_BITS-1:0] tok_ff, tok_in;
   logic [OFFSET_BITS-1:0] span_ff, span_in;
   logic [OFFSET_BITS-1:0] key_start_ff, key_start_in;
   logic [OFFSET_BITS-1:0] key_len_ff, key_len_in;
   logic [3:0]             vcnt_ff, vcnt_in;
   logic                   ok10_ff, ok10_in;
   logic                   ok11_ff, ok11_in;
   logic [1:0]             ver_result_ff, ver_result_in;

   function automatic hrp_pkg::rsp_type make_record(hrp_pkg::ctx_type c,
                                                     logic [7:0] ob);
      hrp_pkg::rsp_type r;
      r          = '0;
      r.out_byte = ob;
      if (c.phase == hrp_pkg::PH_REQ_LF) begin
         r.record_kind  = hrp_pkg::KIND_REQUEST;
         r.method_code  = c.chosen;
         r.version_code = c.ver_result;
         r.first_offset = c.tok[15:0];
         r.first_length = c.span[15:0];
      end else begin
         r.record_kind   = hrp_pkg::KIND_HEADER;
         r.first_offset  = c.key_start[15:0];
         r.first_length  = c.key_len[15:0];
         r.second_offset = c.tok[15:0];
         r.second_length = c.span[15:0];
      end
      return r;
   endfunction

   always_comb begin
      hrp_pkg::ctx_type             c;
      hrp_pkg::rsp_type             rec;
      logic [7:0]                   b;
      logic [7:0]                   ob;
      logic [hrp_pkg::POS_WIDTH-1:0] pos;
      logic [hrp_pkg::POS_WIDTH-1:0] nxt;
      logic                         emitted;

      b   = item.data;
      ob  = b;
      pos = hrp_pkg::POS_WIDTH'(pos_ff);
      nxt = (pos + 1) & POS_MASK;
      emitted = 1'b0;
      rec = '0;

      c.phase      = phase_ff;
      c.alive      = alive_ff;
      c.chosen     = chosen_ff;
      c.head       = head_ff;
      c.tok        = hrp_pkg::POS_WIDTH'(tok_ff);
      c.span       = hrp_pkg::POS_WIDTH'(span_ff);
      c.key_start  = hrp_pkg::POS_WIDTH'(key_start_ff);
      c.key_len    = hrp_pkg::POS_WIDTH'(key_len_ff);
      c.vcnt       = vcnt_ff;
      c.ok10       = ok10_ff;
      c.ok11       = ok11_ff;
      c.ver_result = ver_result_ff;

      case (phase_ff)
         hrp_pkg::PH_METHOD: begin
            if (b == hrp_pkg::CHAR_CR) begin
               c = hrp_pkg::finish_request(c, pos);
            end else begin
               if (pos < 32'd8) begin
                  c.head[{pos[2:0], 3'b000} +: 8] = b;
                  for (int i = 0; i < hrp_pkg::METHOD_COUNT - 1; i++) begin
                     if ((b & ~hrp_pkg::method_pat(4'(i), pos[2:0])) != 8'd0)
                        c.alive[i] = 1'b0;
                  end
               end
               if (pos >= 32'd7) c = hrp_pkg::decide(c, 32'd8);
            end
         end
         hrp_pkg::PH_TGT_SKIP, hrp_pkg::PH_TARGET,
         hrp_pkg::PH_VER_SKIP, hrp_pkg::PH_VERSION: begin
            if (b == hrp_pkg::CHAR_CR) c = hrp_pkg::finish_request(c, pos);
            else                       c = hrp_pkg::scan_step(c, b, pos);
         end
         hrp_pkg::PH_REQ_LF, hrp_pkg::PH_HDR_LF: begin
            rec         = make_record(c, ob);
            emitted     = 1'b1;
            c.phase     = hrp_pkg::PH_KEY;
            c.key_start = nxt;
         end
         hrp_pkg::PH_KEY: begin
            if (b == hrp_pkg::CHAR_CR) begin
               c = hrp_pkg::finish_header(c, pos);
            end else if (b == hrp_pkg::CHAR_COLON) begin
               c.key_len = pos - c.key_start;
               c.phase   = hrp_pkg::PH_VAL_SKIP;
            end else if (b >= hrp_pkg::CHAR_UC_A && b <= hrp_pkg::CHAR_UC_Z) begin
               ob = b + hrp_pkg::CASE_DELTA;
               rec.out_byte = ob;
            end
         end
         hrp_pkg::PH_VAL_SKIP: begin
            if (b == hrp_pkg::CHAR_CR) begin
               c = hrp_pkg::finish_header(c, pos);
            end else if (!hrp_pkg::is_blank(b)) begin
               c.tok   = pos;
               c.phase = hrp_pkg::PH_VALUE;
            end
         end
         hrp_pkg::PH_VALUE: begin
            if (b == hrp_pkg::CHAR_CR) c = hrp_pkg::finish_header(c, pos);
         end
         default: begin
         end
      endcase

      if (item.last) begin
         if (c.phase <= hrp_pkg::PH_VERSION)
            c = hrp_pkg::finish_request(c, nxt);
         else if (c.phase >= hrp_pkg::PH_KEY && c.phase <= hrp_pkg::PH_VALUE)
            c = hrp_pkg::finish_header(c, nxt);
      end

      // keep offsets modulo the position width
      c.tok       = c.tok & POS_MASK;
      c.span      = c.span & POS_MASK;
      c.key_start = c.key_start & POS_MASK;
      c.key_len   = c.key_len & POS_MASK;

      if (item.last && !emitted &&
          (c.phase == hrp_pkg::PH_REQ_LF || c.phase == hrp_pkg::PH_HDR_LF))
         rec = make_record(c, ob);
      if (!emitted && rec.record_kind == hrp_pkg::KIND_NONE) rec.out_byte = ob;

      result = rec;

      phase_in      = c.phase;
      pos_in        = nxt[OFFSET_BITS-1:0];
      alive_in      = c.alive;
      chosen_in     = c.chosen;
      head_in       = c.head;
      tok_in        = c.tok[OFFSET_BITS-1:0];
      span_in       = c.span[OFFSET_BITS-1:0];
      key_start_in  = c.key_start[OFFSET_BITS-1:0];
      key_len_in    = c.key_len[OFFSET_BITS-1:0];
      vcnt_in       = c.vcnt;
      ok10_in       = c.ok10;
      ok11_in       = c.ok11;
      ver_result_in = c.ver_result;

      if (item.last) begin
         phase_in      = hrp_pkg::PH_METHOD;
         pos_in        = '0;
         alive_in      = '1;
         chosen_in     = '0;
         head_in       = '0;
         tok_in        = '0;
         span_in       = '0;
         key_start_in  = '0;
         key_len_in    = '0;
         vcnt_in       = '0;
         ok10_in       = 1'b0;
         ok11_in       = 1'b0;
         ver_result_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= hrp_pkg::PH_METHOD;
         pos_ff        <= '0;
         alive_ff      <= '1;
         chosen_ff     <= '0;
         head_ff       <= '0;
         tok_ff        <= '0;
         span_ff       <= '0;
         key_start_ff  <= '0;
         key_len_ff    <= '0;
         vcnt_ff       <= '0;
         ok10_ff       <= 1'b0;
         ok11_ff       <= 1'b0;
         ver_result_ff <= '0;
      end else if (fire) begin
         phase_ff      <= phase_in;
         pos_ff        <= pos_in;
         alive_ff      <= alive_in;
         chosen_ff     <= chosen_in;
         head_ff       <= head_in;
         tok_ff        <= tok_in;
         span_ff       <= span_in;
         key_start_ff  <= key_start_in;
         key_len_ff    <= key_len_in;
         vcnt_ff       <= vcnt_in;
         ok10_ff       <= ok10_in;
         ok11_ff       <= ok11_in;
         ver_result_ff <= ver_result_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/hrp_output_stage.sv =====
// Output register: holds one result transaction until the consumer takes it.
`default_nettype none
module hrp_output_stage (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               fire,
   input  wire hrp_pkg::rsp_type                   result,
   output logic                                    space,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic [hrp_pkg::RSP_DATA_WIDTH-1:0]      rsp_tdata,
   output logic [1:0]                              rsp_tuser
);

   logic             valid_ff;
   logic             valid_in;
   hrp_pkg::rsp_type data_ff;

   assign space      = !valid_ff || rsp_tready;
   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = data_ff.record_kind;
   assign rsp_tdata  = {2'b00,
                        data_ff.second_length,
                        data_ff.second_offset,
                        data_ff.first_length,
                        data_ff.first_offset,
                        data_ff.version_code,
                        data_ff.method_code,
                        data_ff.out_byte};

   always_comb begin
      valid_in = valid_ff;
      if (fire)            valid_in = 1'b1;
      else if (rsp_tready) valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         data_ff <= result;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/http_request_header_parser.sv =====
// Top level of the HTTP request header parser: input register, parse engine, output register.
//
//   channel  dir  ports                      carries
//   req      in   req_tvalid/tready/tdata/   one header byte a transaction, tlast on the
//                 tlast                      final byte of the block
//   rsp      out  rsp_tvalid/tready/tdata/   the byte back (keys lowercased) plus the
//                 tuser                      record kind and its method/version/spans
//
// One byte a cycle sustained while rsp_tready holds; each accepted byte passes the input
// register, then the combinational parse step into the output register.
// The per-byte step is bounded by the method decision, which rescans up to eight held
// bytes of the request line in the same cycle.
// Reset (synchronous) empties both registers and returns the parser to the method phase.
// A stalled rsp side holds the result; req takes at most one more byte into the input register.
`default_nettype none
module http_request_header_parser #(
   parameter int OFFSET_BITS = hrp_pkg::OFFSET_BITS_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [7:0]                         req_tdata,  // [7:0] in_byte
   input  wire logic                               req_tlast,  // end_of_block
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // [7:0] out_byte, [11:8] method_code, [13:12] version_code, [29:14] first_offset,
   // [45:30] first_length, [61:46] second_offset, [77:62] second_length, [79:78] zero
   output logic [hrp_pkg::RSP_DATA_WIDTH-1:0]      rsp_tdata,
   output logic [1:0]                              rsp_tuser   // [1:0] record_kind
);

   logic             item_valid;
   logic             space;
   logic             fire;
   hrp_pkg::req_type item;
   hrp_pkg::rsp_type result;

   assign fire = item_valid && space;

   hrp_input_stage u_input (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .fire       (fire),
      .item_valid (item_valid),
      .item       (item)
   );

   hrp_parse_engine #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_engine (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (item),
      .result (result)
   );

   hrp_output_stage u_output (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .result     (result),
      .space      (space),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
`default_nettype wire

// ===== verif/http_request_header_parser_test.sv =====
// Self-checking testbench for the HTTP request header parser: directed blocks, then random.
module http_request_header_parser_test;
   timeunit 1ns;
   timeprecision 1ps;
   import hrp_pkg::*;

   // method name patterns, first byte in the top bits; 8'hff matches anything
   localparam logic [8:0][63:0] NAME_PATTERN = {
      {"PATH", {4{8'hff}}}, {"TRACE", {3{8'hff}}}, {"OPTIONS", 8'hff},
      {"CONNECT", 8'hff}, {"DELETE", {2{8'hff}}}, {"PUT", {5{8'hff}}},
      {"POST", {4{8'hff}}}, {"HEAD", {4{8'hff}}}, {"GET", {5{8'hff}}}};
   localparam logic [9:0][3:0] NAME_LENGTH = {4'd0, 4'd4, 4'd5, 4'd7, 4'd7, 4'd6,
                                              4'd3, 4'd4, 4'd4, 4'd3};
   // version text as collected, first byte in the low bits
   localparam logic [63:0] HTTP10_LE = 64'h302E312F50545448;
   localparam logic [63:0] HTTP11_LE = 64'h312E312F50545448;
   localparam logic [6:0]  NO_PIN    = 7'd0;
   localparam int          DIRECTED_ROWS = 14;
   localparam int          RANDOM_ITEMS  = 480;
   localparam int          HOLD_CYCLES   = 300;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   // Directed blocks; tlast goes on the final byte of each. '~' stands for a zero byte.
   // A pinned row carries {1, method, version} for its request record.
   string directed_text [0:DIRECTED_ROWS-1] = '{
      "GET / HTTP/1.1\r\nHost: A\r\n\r\n",
      "HEAD\r\n",
      "get / HTTP/1.0\r\n\r\n",
      "POST /a HTTP/1.0\r\nX-Key:\r\nNoColon\r\n\r\n",
      "PUT\t/x\t\tHTTP/1.1\r\nAcCePt:\t \377~z\r\n\r\n",
      "DELETE /\r\n\r\n",
      "CONNEC\r\n",
      "OPTIONS * HTTP/1.1\rZK: v\r\n\r\n",
      "TRACE / HTTP/1.1x\r\n\r\n",
      "PATH /p HTTP/1.",
      "GET / HTTP/1.0\r\nK: v\r",
      "GET / HTTP/1.0\r\nKEY",
      "~\r\n",
      "GET / HTTP/1.1\r\n\r\nJUNK"};
   logic [6:0] directed_pin [0:DIRECTED_ROWS-1] = '{
      {1'b1, METHOD_GET, VER_CODE_11}, {1'b1, METHOD_HEAD, VER_CODE_BAD},
      {1'b1, METHOD_UNKNOWN, VER_CODE_BAD}, NO_PIN, NO_PIN, NO_PIN, NO_PIN, NO_PIN,
      NO_PIN, NO_PIN, NO_PIN, NO_PIN, NO_PIN, NO_PIN};

   // parser model state
   phase_type   parser_phase;
   logic [15:0] block_pos;
   logic [9:0]  method_alive;
   logic [3:0]  method_pick;
   logic [63:0] version_text;
   logic [15:0] token_pos;
   logic [15:0] token_len;
   logic [15:0] key_pos;
   logic [15:0] key_len;
   logic [3:0]  version_bytes;
   logic [63:0] line_head;
   logic [1:0]  version_verdict;

   rsp_type     expected_records [$];
   rsp_type     seen_rsp;
   rsp_type     due_rsp;
   logic [8:0]  block_q [$];    // {last, byte}
   int          failures = 0;
   int          items_sent = 0;
   int          blocks_sent = 0;
   int          request_records = 0;
   int          header_records = 0;
   int          idle_pct = 0;
   int          stall_pct = 0;
   bit          hold_wanted = 1'b0;
   int          hold_left = 0;

   http_request_header_parser dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic bit whitespace(logic [7:0] b);
      return (b == " ") || (b == "\t");
   endfunction

   task automatic parser_clear();
      parser_phase    = PH_METHOD;
      block_pos       = '0;
      method_alive    = '1;
      method_pick     = METHOD_GET;
      version_text    = '0;
      token_pos       = '0;
      token_len       = '0;
      key_pos         = '0;
      key_len         = '0;
      version_bytes   = '0;
      line_head       = '0;
      version_verdict = VER_CODE_10;
   endtask

   // target and version tracking on the request line
   task automatic scan_request_byte(input logic [7:0] b, input logic [15:0] pos);
      case (parser_phase)
         PH_TGT_SKIP: begin
            if (!whitespace(b)) begin
               token_pos    = pos;
               parser_phase = PH_TARGET;
            end
         end
         PH_TARGET: begin
            if (whitespace(b)) begin
               token_len    = pos - token_pos;
               parser_phase = PH_VER_SKIP;
            end
         end
         PH_VER_SKIP: begin
            if (!whitespace(b)) begin
               version_text  = {56'd0, b};
               version_bytes = 4'd1;
               parser_phase  = PH_VERSION;
            end
         end
         PH_VERSION: begin
            if (version_bytes < 4'd8) begin
               version_text  = version_text | (64'(b) << (8 * version_bytes));
               version_bytes = version_bytes + 4'd1;
            end else begin
               version_bytes = 4'd9;
            end
         end
         default: begin
         end
      endcase
   endtask

   // first live method wins; the held bytes past its name are replayed into the scan
   task automatic resolve_method(input int stored);
      int i;
      int p;
      method_pick = METHOD_UNKNOWN;
      for (i = 0; i < 10; i++) begin
         if (method_alive[i]) begin
            method_pick = 4'(i);
            break;
         end
      end
      parser_phase = PH_TGT_SKIP;
      if (stored > 8) stored = 8;
      for (p = int'(NAME_LENGTH[method_pick]); p < stored; p++)
         scan_request_byte(line_head[8*p +: 8], 16'(p));
   endtask

   task automatic end_request_line(input logic [15:0] e);
      if (parser_phase == PH_METHOD) resolve_method(int'(e));
      version_verdict = VER_CODE_BAD;
      case (parser_phase)
         PH_TGT_SKIP: begin
            token_pos = e;
            token_len = '0;
         end
         PH_TARGET: token_len = e - token_pos;
         PH_VERSION: begin
            if (version_bytes == 4'd8 && version_text == HTTP10_LE)
               version_verdict = VER_CODE_10;
            else if (version_bytes == 4'd8 && version_text == HTTP11_LE)
               version_verdict = VER_CODE_11;
         end
         default: begin
         end
      endcase
      parser_phase = PH_REQ_LF;
   endtask

   task automatic end_header_line(input logic [15:0] e);
      if (parser_phase == PH_KEY && e == key_pos) begin
         parser_phase = PH_DONE;     // blank line: rest of the block is ignored
      end else begin
         case (parser_phase)
            PH_KEY: begin
               key_len   = e - key_pos;
               token_pos = e;
               token_len = '0;
            end
            PH_VAL_SKIP: begin
               token_pos = e;
               token_len = '0;
            end
            PH_VALUE: token_len = e - token_pos;
            default: begin
            end
         endcase
         parser_phase = PH_HDR_LF;
      end
   endtask

   task automatic put_record(inout rsp_type r);
      if (parser_phase == PH_REQ_LF) begin
         r.record_kind  = KIND_REQUEST;
         r.method_code  = method_pick;
         r.version_code = version_verdict;
         r.first_offset = token_pos;
         r.first_length = token_len;
      end else begin
         r.record_kind   = KIND_HEADER;
         r.first_offset  = key_pos;
         r.first_length  = key_len;
         r.second_offset = token_pos;
         r.second_length = token_len;
      end
   endtask

   task automatic predict_byte(input logic [7:0] b, input logic last, output rsp_type r);
      logic [15:0] pos;
      logic [15:0] nxt;
      logic [63:0] pattern;
      bit          emitted;
      int          i;
      int          p;
      pos = block_pos;
      nxt = pos + 16'd1;
      emitted = 1'b0;
      r = '0;
      r.out_byte = b;
      case (parser_phase)
         PH_METHOD: begin
            if (b == "\r") begin
               end_request_line(pos);
            end else begin
               if (pos < 16'd8) begin
                  p = int'(pos);
                  line_head[8*p +: 8] = b;
                  for (i = 0; i < 9; i++) begin
                     pattern = NAME_PATTERN[i];
                     if ((b & ~pattern[8*(7-p) +: 8]) != 8'h00) method_alive[i] = 1'b0;
                  end
               end
               if (pos >= 16'd7) resolve_method(8);
            end
         end
         PH_TGT_SKIP, PH_TARGET, PH_VER_SKIP, PH_VERSION: begin
            if (b == "\r") end_request_line(pos);
            else scan_request_byte(b, pos);
         end
         PH_REQ_LF, PH_HDR_LF: begin
            // whatever follows the CR closes the line and carries its record
            put_record(r);
            emitted = 1'b1;
            parser_phase = PH_KEY;
            key_pos = nxt;
         end
         PH_KEY: begin
            if (b == "\r") begin
               end_header_line(pos);
            end else if (b == ":") begin
               key_len = pos - key_pos;
               parser_phase = PH_VAL_SKIP;
            end else if (b >= "A" && b <= "Z") begin
               r.out_byte = b + 8'h20;
            end
         end
         PH_VAL_SKIP: begin
            if (b == "\r") begin
               end_header_line(pos);
            end else if (!whitespace(b)) begin
               token_pos = pos;
               parser_phase = PH_VALUE;
            end
         end
         PH_VALUE: begin
            if (b == "\r") end_header_line(pos);
         end
         default: begin
         end
      endcase
      block_pos = nxt;
      if (last) begin
         if (parser_phase <= PH_VERSION) end_request_line(nxt);
         else if (parser_phase >= PH_KEY && parser_phase <= PH_VALUE) end_header_line(nxt);
         if (!emitted && (parser_phase == PH_REQ_LF || parser_phase == PH_HDR_LF))
            put_record(r);
         parser_clear();
      end
   endtask

   // one byte onto the bus; expectation is queued once the transaction is taken
   task automatic send_item(input logic [7:0] b, input logic last, input logic [6:0] pin);
      rsp_type want;
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_byte(b, last, want);
      if (pin[6] && want.record_kind == KIND_REQUEST) begin
         want.method_code  = pin[5:2];
         want.version_code = pin[1:0];
      end
      expected_records.push_back(want);
      items_sent++;
   endtask

   task automatic send_block(input logic [6:0] pin);
      int i;
      for (i = 0; i < block_q.size(); i++)
         send_item(block_q[i][7:0], i == block_q.size() - 1, pin);
      blocks_sent++;
   endtask

   task automatic add_text(input string s);
      int i;
      logic [7:0] c;
      for (i = 0; i < s.len(); i++) begin
         c = s[i];
         if (c == "~") c = 8'h00;
         block_q.push_back({1'b0, c});
      end
   endtask

   task automatic add_blanks(input int n);
      repeat (n) block_q.push_back({1'b0, ($urandom_range(1) != 0) ? 8'h20 : 8'h09});
   endtask

   task automatic add_random(input int n, input int lo, input int hi);
      repeat (n) block_q.push_back({1'b0, 8'($urandom_range(hi, lo))});
   endtask

   // mostly well-formed request blocks with random content, some noise and cut blocks
   task automatic build_random_block();
      int shape;
      int n;
      int h;
      logic [7:0] c;
      block_q.delete();
      shape = $urandom_range(99);
      if (shape < 10) begin
         add_random($urandom_range(1, 12), 0, 255);
      end else begin
         case ($urandom_range(10))
            0: add_text("GET");
            1: add_text("HEAD");
            2: add_text("POST");
            3: add_text("PUT");
            4: add_text("DELETE");
            5: add_text("CONNECT");
            6: add_text("OPTIONS");
            7: add_text("TRACE");
            8: add_text("PATH");
            9: add_random($urandom_range(1, 10), 8'h41, 8'h5a);
            default: add_random($urandom_range(1, 9), 0, 255);
         endcase
         add_blanks(($urandom_range(9) == 0) ? 0 : $urandom_range(1, 2));
         add_random($urandom_range(0, 10), 8'h21, 8'h7e);
         add_blanks(($urandom_range(9) == 0) ? 0 : $urandom_range(1, 2));
         case ($urandom_range(9))
            0, 1, 2, 3: add_text("HTTP/1.1");
            4, 5, 6: add_text("HTTP/1.0");
            7: begin
               add_text("HTTP/1.1");
               n = block_q.size() - 1 - $urandom_range(7);
               block_q[n] = block_q[n] ^ (9'd1 << $urandom_range(7));
            end
            8: add_text("HTTP/1.");
            default: add_text("HTTP/1.10");
         endcase
         add_text("\r");
         if ($urandom_range(11) == 0) add_random(1, 0, 255);
         else add_text("\n");
         h = $urandom_range(0, 4);
         repeat (h) begin
            n = $urandom_range(0, 8);
            if (n == 0 && $urandom_range(1) == 0) n = 1;
            repeat (n) begin
               case ($urandom_range(5))
                  0, 1: c = 8'($urandom_range(8'h5a, 8'h41));
                  2: c = 8'($urandom_range(8'h7a, 8'h61));
                  3: c = 8'($urandom_range(8'h39, 8'h30));
                  4: c = "-";
                  default: c = ($urandom_range(1) != 0) ? 8'h40 : 8'h5b;  // just outside A..Z
               endcase
               block_q.push_back({1'b0, c});
            end
            if ($urandom_range(9) != 0) add_text(":");
            add_blanks($urandom_range(0, 2));
            n = $urandom_range(0, 10);
            repeat (n) begin
               c = ($urandom_range(7) == 0) ? 8'($urandom_range(255))
                                            : 8'($urandom_range(8'h7e, 8'h20));
               if (c == "\r") c = 8'h0a;
               block_q.push_back({1'b0, c});
            end
            add_text("\r\n");
         end
         if ($urandom_range(11) != 0) add_text("\r\n");
         if ($urandom_range(7) == 0) add_random($urandom_range(1, 3), 0, 255);
         if ($urandom_range(9) == 0) begin
            n = $urandom_range(1, block_q.size() - 1);
            repeat (n) void'(block_q.pop_back());
         end
      end
      if (block_q.size() == 0) add_random(1, 0, 255);
   endtask

   // lower valid and wait for every outstanding result
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_records.size() != 0);
   endtask

   task automatic compare_field(input string name, input logic [15:0] want,
                                input logic [15:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         failures++;
      end
   endtask

   // receiver: random stalls, plus one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left = hold_left - 1;
      end else if (hold_wanted) begin
         hold_wanted = 1'b0;
         hold_left = HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen_rsp = '0;
         seen_rsp.out_byte      = rsp_tdata[7:0];
         seen_rsp.method_code   = rsp_tdata[11:8];
         seen_rsp.version_code  = rsp_tdata[13:12];
         seen_rsp.first_offset  = rsp_tdata[29:14];
         seen_rsp.first_length  = rsp_tdata[45:30];
         seen_rsp.second_offset = rsp_tdata[61:46];
         seen_rsp.second_length = rsp_tdata[77:62];
         seen_rsp.record_kind   = rsp_tuser;
         if (expected_records.size() == 0) begin
            $display("%0t ns: unexpected transaction, tdata %h tuser %0d", $time,
                     rsp_tdata, rsp_tuser);
            failures++;
         end else begin
            due_rsp = expected_records.pop_front();
            compare_field("out_byte", 16'(due_rsp.out_byte), 16'(seen_rsp.out_byte));
            compare_field("record_kind", 16'(due_rsp.record_kind),
                          16'(seen_rsp.record_kind));
            compare_field("method_code", 16'(due_rsp.method_code),
                          16'(seen_rsp.method_code));
            compare_field("version_code", 16'(due_rsp.version_code),
                          16'(seen_rsp.version_code));
            compare_field("first_offset", due_rsp.first_offset, seen_rsp.first_offset);
            compare_field("first_length", due_rsp.first_length, seen_rsp.first_length);
            compare_field("second_offset", due_rsp.second_offset, seen_rsp.second_offset);
            compare_field("second_length", due_rsp.second_length, seen_rsp.second_length);
            if (due_rsp.record_kind == KIND_REQUEST) request_records++;
            if (due_rsp.record_kind == KIND_HEADER) header_records++;
         end
      end
   end

   initial begin : stimulus
      int row;
      int random_start;
      int mode;
      int cur_mode;
      parser_clear();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (row = 0; row < DIRECTED_ROWS; row++) begin
         block_q.delete();
         add_text(directed_text[row]);
         send_block(directed_pin[row]);
      end

      // long receiver hold-off while the sender keeps pushing
      hold_wanted = 1'b1;
      random_start = items_sent;
      cur_mode = 0;
      while (items_sent - random_start < RANDOM_ITEMS) begin
         mode = ((items_sent - random_start) / (RANDOM_ITEMS / 4)) % 4;
         if (mode != cur_mode) begin
            drain_results();
            cur_mode = mode;
            case (mode)
               1: begin
                  idle_pct = 68;
                  stall_pct = 0;
               end
               2: begin
                  idle_pct = 0;
                  stall_pct = 68;
               end
               default: begin
                  idle_pct = 8;
                  stall_pct = 8;
               end
            endcase
         end
         build_random_block();
         send_block(NO_PIN);
      end

      drain_results();
      repeat (8) @(posedge clock);
      $display("Covered %0d transactions in %0d header blocks: %0d request and %0d header records.",
               items_sent, blocks_sent, request_records, header_records);
      $display("Flow control: free-running, sender gaps, receiver stalls, both, one long hold-off.");
      if (failures == 0) begin
         $display("http_request_header_parser test passed");
      end else begin
         $display("http_request_header_parser test failed");
      end
      $finish;
   end

   initial begin : watchdog
      #4_000_000;
      $display("http_request_header_parser test failed");
      $finish;
   end

endmodule

// ===== http_request_header_parser.f =====
rtl/core/hrp_pkg.sv
rtl/core/hrp_input_stage.sv
rtl/core/hrp_parse_engine.sv
rtl/core/hrp_output_stage.sv
rtl/core/http_request_header_parser.sv
verif/http_request_header_parser_test.sv
